// ----- hw/rtl/sorted_deadline_timer_pool_unit_assert.svh -----
// Assertion helpers for the timer pool.
`ifndef SORTED_DEADLINE_TIMER_POOL_UNIT_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_POOL_UNIT_ASSERT_SVH

// Checked on every rising edge once reset is released.
`define SDTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SDTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/sdtp_pkg.sv -----
package sdtp_pkg;

  // Default sizes and fixed widths.
  localparam int NumTimersDef = 32;
  localparam int NumQueuesDef = 16;
  localparam int MaxEvents    = 32;
  localparam int TimeW        = 32;
  localparam int DestW        = 4;
  localparam int RangeW       = 9;
  localparam logic [TimeW-1:0] NoDeadline = 32'hffff_ffff;

  // Command codes.
  typedef enum logic [2:0] {
    ModeTick  = 3'd0,
    ModeAlloc = 3'd1,
    ModeFree  = 3'd2,
    ModeBind  = 3'd3,
    ModeArm   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNoFree   = 2'd1,
    StatusBadState = 2'd2
  } status_e;

  typedef enum logic {
    KindReply = 1'b0,
    KindEvent = 1'b1
  } kind_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    StIdle,
    StDispatch,
    StArmWalk,
    StArmPut,
    StFreeWalk,
    StTickHead,
    StTickExp,
    StTickCmp,
    StReply
  } state_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [4:0]        timer_id;
    logic [3:0]        dest_queue;
    logic signed [31:0] payload;
    logic [31:0]       delay;
  } in_beat_t;

  typedef struct packed {
    logic              kind;
    logic [1:0]        status;
    logic [4:0]        handle;
    logic [3:0]        dest_out;
    logic signed [31:0] data_out;
    logic              last;
  } out_beat_t;

endpackage

// ----- hw/rtl/sdtp_ram.sv -----
module sdtp_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port; read data holds without a read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/sorted_deadline_timer_pool_unit.sv -----
// A command is taken only in idle and decoded in the dispatch state; all but ticks and unknown modes are
// replied to once the output is not stalled. Arming an allocated timer into a non-empty list and freeing an
// armed timer first walk the list. One command at a time; a tick emits one event beat per fired timer, up to
// MaxEvents, then moves each remaining list entry to the front, entry by entry, via the list RAM's one read port.
// Reset: all timers free, list empty, tick count zero, next deadline all ones.
// The memories need no clearing pass; their contents are undefined until written.
module sorted_deadline_timer_pool_unit import sdtp_pkg::*; #(
  parameter int NumTimers = NumTimersDef,
  parameter int NumQueues = NumQueuesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  localparam int IW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int CW = $clog2(NumTimers + 1);
  localparam int LW = IW + TimeW;
  localparam int DW = DestW + TimeW;

  state_e state_q, state_d;
  in_beat_t cmd_q, cmd_d;
  logic [TimeW-1:0] tick_q, tick_d;
  logic [TimeW-1:0] next_q, next_d;
  logic [TimeW-1:0] newdl_q, newdl_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] rp_q, rp_d;
  logic [CW-1:0] wp_q, wp_d;
  logic [CW-1:0] rem_q, rem_d;
  logic found_q, found_d;
  logic [IW-1:0] cur_id_q, cur_id_d;
  logic [NumTimers-1:0] alloc_q, alloc_d;
  logic [NumTimers-1:0] armed_q, armed_d;
  logic [1:0] rep_status_q, rep_status_d;
  logic [4:0] rep_handle_q, rep_handle_d;
  logic out_valid_q, out_valid_d;
  out_beat_t out_beat_q, out_beat_d;

  // Memory ports.
  logic lst_we, lst_re, dat_we, dat_re;
  logic [IW-1:0] lst_waddr, lst_raddr, dat_waddr, dat_raddr;
  logic [LW-1:0] lst_wdata, lst_rdata;
  logic [DW-1:0] dat_wdata, dat_rdata;

  // Shared decode.
  logic [IW-1:0] tid;
  logic id_ok, dq_ok, can_emit, tick_hit, e2exp, free_found;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] lst_id;
  logic [TimeW-1:0] lst_dl, tick_inc, arm_dl;
  logic [CW-1:0] n1, rem_after;

  assign lst_id    = lst_rdata[LW-1:TimeW];
  assign lst_dl    = lst_rdata[TimeW-1:0];
  assign tid       = IW'(cmd_q.timer_id);
  assign id_ok     = RangeW'(cmd_q.timer_id) < RangeW'(NumTimers);
  assign dq_ok     = RangeW'(cmd_q.dest_queue) < RangeW'(NumQueues);
  assign can_emit  = !out_valid_q || !out_stall_i;
  assign tick_inc  = tick_q + TimeW'(1);
  assign arm_dl    = tick_q + cmd_q.delay;
  assign tick_hit  = (cnt_q != '0) && (next_q <= tick_inc);
  assign n1        = n_q + CW'(1);
  assign rem_after = cnt_q - n1;
  assign e2exp     = (n1 < cnt_q) && (int'(n1) < MaxEvents) && (lst_dl <= tick_q);

  // Lowest free timer.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NumTimers - 1; i >= 0; i--) begin
      if (!alloc_q[i] && !armed_q[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // Sorted list of {timer, deadline}.
  sdtp_ram #(.Width(LW), .Depth(NumTimers)) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (lst_we),
    .waddr_i (lst_waddr),
    .wdata_i (lst_wdata),
    .re_i    (lst_re),
    .raddr_i (lst_raddr),
    .rdata_o (lst_rdata)
  );

  // Per-timer destination and payload.
  sdtp_ram #(.Width(DW), .Depth(NumTimers)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .waddr_i (dat_waddr),
    .wdata_i (dat_wdata),
    .re_i    (dat_re),
    .raddr_i (dat_raddr),
    .rdata_o (dat_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StDispatch;
      end
      StDispatch: begin
        unique case (cmd_q.mode)
          ModeTick:  state_d = tick_hit ? StTickHead : StIdle;
          ModeAlloc, ModeBind: state_d = StReply;
          ModeFree:  state_d = (id_ok && armed_q[tid]) ? StFreeWalk : StReply;
          ModeArm: begin
            state_d = (id_ok && alloc_q[tid] && cnt_q != '0) ? StArmWalk : StReply;
          end
          default:   state_d = StIdle;
        endcase
      end
      StArmWalk: begin
        if (lst_dl >= newdl_q) begin
          if (wp_q == CW'(1)) state_d = StArmPut;
        end else begin
          state_d = StReply;
        end
      end
      StArmPut:   state_d = StReply;
      StFreeWalk: begin
        if (rp_q == cnt_q) state_d = StReply;
      end
      StTickHead: state_d = StTickExp;
      StTickExp: begin
        if (can_emit && !e2exp) state_d = (rem_after == '0) ? StIdle : StTickCmp;
      end
      StTickCmp: begin
        if (wp_q + CW'(1) == rem_q) state_d = StIdle;
      end
      StReply: begin
        if (can_emit) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cmd_d        = cmd_q;
    tick_d       = tick_q;
    next_d       = next_q;
    newdl_d      = newdl_q;
    cnt_d        = cnt_q;
    n_d          = n_q;
    rp_d         = rp_q;
    wp_d         = wp_q;
    rem_d        = rem_q;
    found_d      = found_q;
    cur_id_d     = cur_id_q;
    alloc_d      = alloc_q;
    armed_d      = armed_q;
    rep_status_d = rep_status_q;
    rep_handle_d = rep_handle_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_beat_d   = out_beat_q;
    lst_we = 1'b0; lst_waddr = '0; lst_wdata = lst_rdata;
    lst_re = 1'b0; lst_raddr = '0;
    dat_we = 1'b0; dat_waddr = tid; dat_wdata = {cmd_q.dest_queue, cmd_q.payload};
    dat_re = 1'b0; dat_raddr = lst_id;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) cmd_d = in_beat_i;
      end
      StDispatch: begin
        rep_status_d = StatusOk;
        rep_handle_d = '0;
        unique case (cmd_q.mode)
          ModeTick: begin
            tick_d = tick_inc;
            if (tick_hit) begin
              lst_re    = 1'b1;
              lst_raddr = '0;
            end
          end
          ModeAlloc: begin
            if (free_found) begin
              alloc_d[free_idx] = 1'b1;
              rep_handle_d      = 5'(free_idx);
            end else begin
              rep_status_d = StatusNoFree;
            end
          end
          ModeFree: begin
            if (!id_ok) begin
              rep_status_d = StatusBadState;
            end else begin
              if (armed_q[tid]) begin
                lst_re    = 1'b1;
                lst_raddr = '0;
                rp_d      = CW'(1);
                found_d   = 1'b0;
              end
              alloc_d[tid] = 1'b0;
              armed_d[tid] = 1'b0;
            end
          end
          ModeBind: begin
            if (id_ok && dq_ok) dat_we = 1'b1;
            else rep_status_d = StatusBadState;
          end
          ModeArm: begin
            if (id_ok && alloc_q[tid]) begin
              alloc_d[tid] = 1'b0;
              armed_d[tid] = 1'b1;
              newdl_d      = arm_dl;
              if (cnt_q == '0) begin
                lst_we    = 1'b1;
                lst_waddr = '0;
                lst_wdata = {tid, arm_dl};
                next_d    = arm_dl;
                cnt_d     = CW'(1);
              end else begin
                lst_re    = 1'b1;
                lst_raddr = IW'(cnt_q - CW'(1));
                wp_d      = cnt_q;
              end
            end else begin
              rep_status_d = StatusBadState;
            end
          end
          default: ;
        endcase
      end
      // Walk from the tail, shifting entries not earlier than the new deadline.
      StArmWalk: begin
        lst_we    = 1'b1;
        lst_waddr = IW'(wp_q);
        if (lst_dl >= newdl_q) begin
          lst_wdata = lst_rdata;
          if (wp_q != CW'(1)) begin
            lst_re    = 1'b1;
            lst_raddr = IW'(wp_q - CW'(2));
            wp_d      = wp_q - CW'(1);
          end
        end else begin
          lst_wdata = {tid, newdl_q};
          cnt_d     = cnt_q + CW'(1);
        end
      end
      StArmPut: begin
        lst_we    = 1'b1;
        lst_waddr = '0;
        lst_wdata = {tid, newdl_q};
        next_d    = newdl_q;
        cnt_d     = cnt_q + CW'(1);
      end
      // Walk from the head; once the timer is found, pull each later entry up by one.
      StFreeWalk: begin
        if (found_q) begin
          lst_we    = 1'b1;
          lst_waddr = IW'(rp_q - CW'(2));
          lst_wdata = lst_rdata;
          if (rp_q == CW'(2)) next_d = lst_dl;
        end else if (lst_id == tid) begin
          found_d = 1'b1;
          if (rp_q == CW'(1)) next_d = NoDeadline;
        end
        if (rp_q == cnt_q) begin
          cnt_d = cnt_q - CW'(1);
        end else begin
          lst_re    = 1'b1;
          lst_raddr = IW'(rp_q);
          rp_d      = rp_q + CW'(1);
        end
      end
      StTickHead: begin
        cur_id_d  = lst_id;
        dat_re    = 1'b1;
        dat_raddr = lst_id;
        lst_re    = 1'b1;
        lst_raddr = IW'(CW'(1));
        n_d       = '0;
      end
      // One event a beat; the next list entry is already read to set last.
      StTickExp: begin
        if (can_emit) begin
          out_valid_d         = 1'b1;
          out_beat_d.kind     = KindEvent;
          out_beat_d.status   = StatusOk;
          out_beat_d.handle   = 5'(cur_id_q);
          out_beat_d.dest_out = dat_rdata[DW-1:TimeW];
          out_beat_d.data_out = dat_rdata[TimeW-1:0];
          out_beat_d.last     = !e2exp;
          alloc_d[cur_id_q]   = 1'b1;
          armed_d[cur_id_q]   = 1'b0;
          n_d                 = n1;
          if (e2exp) begin
            cur_id_d  = lst_id;
            dat_re    = 1'b1;
            dat_raddr = lst_id;
            lst_re    = 1'b1;
            lst_raddr = IW'(n_q + CW'(2));
          end else if (rem_after == '0) begin
            cnt_d  = '0;
            next_d = NoDeadline;
          end else begin
            lst_re    = 1'b1;
            lst_raddr = IW'(n1);
            rp_d      = n1 + CW'(1);
            wp_d      = '0;
            rem_d     = rem_after;
          end
        end
      end
      // Move the surviving entries to the front.
      StTickCmp: begin
        lst_we    = 1'b1;
        lst_waddr = IW'(wp_q);
        lst_wdata = lst_rdata;
        if (wp_q == '0) next_d = lst_dl;
        if (wp_q + CW'(1) == rem_q) begin
          cnt_d = rem_q;
        end else begin
          lst_re    = 1'b1;
          lst_raddr = IW'(rp_q);
          rp_d      = rp_q + CW'(1);
          wp_d      = wp_q + CW'(1);
        end
      end
      StReply: begin
        if (can_emit) begin
          out_valid_d         = 1'b1;
          out_beat_d.kind     = KindReply;
          out_beat_d.status   = rep_status_q;
          out_beat_d.handle   = rep_handle_q;
          out_beat_d.dest_out = '0;
          out_beat_d.data_out = '0;
          out_beat_d.last     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tick_q      <= '0;
      next_q      <= NoDeadline;
      cnt_q       <= '0;
      alloc_q     <= '0;
      armed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      next_q      <= next_d;
      cnt_q       <= cnt_d;
      alloc_q     <= alloc_d;
      armed_q     <= armed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    newdl_q      <= newdl_d;
    n_q          <= n_d;
    rp_q         <= rp_d;
    wp_q         <= wp_d;
    rem_q        <= rem_d;
    found_q      <= found_d;
    cur_id_q     <= cur_id_d;
    rep_status_q <= rep_status_d;
    rep_handle_q <= rep_handle_d;
    out_beat_q   <= out_beat_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

`include "sorted_deadline_timer_pool_unit_assert.svh"

  // Armed bits and list length agree between commands.
  `SDTP_ASSERT(a_armed_cnt, (state_q == StIdle) |-> ($countones(armed_q) == int'(cnt_q)), "armed count mismatch")
  // A timer is never both allocated and armed; the state bits are only defined out of reset.
  `SDTP_ASSERT_ALWAYS(a_state_excl, (!rst_ni || ((alloc_q & armed_q) == '0)), "timer both allocated and armed")
  // An empty list carries no deadline.
  `SDTP_ASSERT(a_empty_next, (state_q == StIdle && cnt_q == '0) |-> (next_q == NoDeadline), "stale next deadline")

endmodule

// ----- test/sorted_deadline_timer_pool_unit_test.sv -----
`timescale 1ns / 100ps

module sorted_deadline_timer_pool_unit_test;
  import sdtp_pkg::*;

  localparam int NumTimers = NumTimersDef;
  localparam int RandomItems = 390;

  typedef enum logic [1:0] {
    TimerFree  = 2'd0,
    TimerAlloc = 2'd1,
    TimerArmed = 2'd2
  } timer_state_e;

  typedef struct {
    in_beat_t beat;
    int       wait_for;
  } pending_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  sorted_deadline_timer_pool_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  // Predicted pool state.
  timer_state_e timer_st[NumTimers];
  logic [31:0]  timer_deadline[NumTimers];
  logic [3:0]   timer_dest[NumTimers];
  logic [31:0]  timer_payload[NumTimers];
  bit           timer_bound[NumTimers];
  int           armed_list[$];
  logic [31:0]  tick_count;

  pending_t  pending_beats[$];
  out_beat_t expected_results[$];
  int        results_predicted;
  int        results_seen;
  int        beats_sent;
  int        errors;
  bit        in_taken;

  always #6 clk = ~clk;

  function automatic logic [31:0] head_deadline();
    if (armed_list.size() == 0) begin
      return NoDeadline;
    end
    return timer_deadline[armed_list[0]];
  endfunction

  function automatic void expect_reply(status_e st, logic [4:0] handle);
    out_beat_t r;
    r = '0;
    r.kind = KindReply;
    r.status = st;
    r.handle = handle;
    r.last = 1'b1;
    expected_results.push_back(r);
    results_predicted++;
  endfunction

  // Advance the tick count and expire the due timers, head first, at most MaxEvents of them.
  function automatic void predict_tick();
    out_beat_t r;
    int n;
    int id;
    n = 0;
    tick_count++;
    if (head_deadline() > tick_count) begin
      return;
    end
    while (n < armed_list.size() && n < MaxEvents) begin
      id = armed_list[n];
      if (timer_deadline[id] > tick_count) begin
        break;
      end
      timer_st[id] = TimerAlloc;
      r = '0;
      r.kind = KindEvent;
      r.status = StatusOk;
      r.handle = id[4:0];
      r.dest_out = timer_dest[id];
      r.data_out = timer_payload[id];
      expected_results.push_back(r);
      results_predicted++;
      n++;
    end
    if (n > 0) begin
      expected_results[expected_results.size() - 1].last = 1'b1;
    end
    repeat (n) void'(armed_list.pop_front());
  endfunction

  function automatic void predict_beat(in_beat_t b);
    int id;
    int pos;
    bit found;
    id = int'(b.timer_id);
    found = 0;
    case (b.mode)
      ModeTick: begin
        predict_tick();
      end
      ModeAlloc: begin
        for (int i = 0; i < NumTimers; i++) begin
          if (!found && timer_st[i] == TimerFree) begin
            timer_st[i] = TimerAlloc;
            expect_reply(StatusOk, i[4:0]);
            found = 1;
          end
        end
        if (!found) begin
          expect_reply(StatusNoFree, '0);
        end
      end
      ModeFree: begin
        if (timer_st[id] == TimerArmed) begin
          foreach (armed_list[i]) begin
            if (armed_list[i] == id) begin
              pos = i;
            end
          end
          armed_list.delete(pos);
        end
        timer_st[id] = TimerFree;
        expect_reply(StatusOk, '0);
      end
      ModeBind: begin
        timer_dest[id] = b.dest_queue;
        timer_payload[id] = b.payload;
        timer_bound[id] = 1;
        expect_reply(StatusOk, '0);
      end
      ModeArm: begin
        if (timer_st[id] != TimerAlloc) begin
          expect_reply(StatusBadState, '0);
        end else begin
          timer_deadline[id] = tick_count + b.delay;
          timer_st[id] = TimerArmed;
          pos = armed_list.size();
          for (int i = armed_list.size() - 1; i >= 0; i--) begin
            if (timer_deadline[armed_list[i]] >= timer_deadline[id]) begin
              pos = i;
            end
          end
          armed_list.insert(pos, id);
          expect_reply(StatusOk, '0);
        end
      end
      default: begin
        // Unknown modes are dropped without a reply.
      end
    endcase
  endfunction

  function automatic in_beat_t make_beat(logic [2:0] mode, int id, int dq, logic [31:0] pay,
                                         logic [31:0] dly);
    in_beat_t b;
    b.mode = mode;
    b.timer_id = id[4:0];
    b.dest_queue = dq[3:0];
    b.payload = pay;
    b.delay = dly;
    return b;
  endfunction

  // Queue a beat for the driver; a held beat waits until the pool has drained.
  function automatic void send(in_beat_t b, bit hold = 0);
    pending_t p;
    p.beat = b;
    p.wait_for = hold ? results_predicted : -1;
    predict_beat(b);
    pending_beats.push_back(p);
  endfunction

  function automatic logic [31:0] pick_delay();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 6);
      6, 7: return $urandom_range(0, 40);
      8: return $urandom;
      default: return 32'hffff_ffff - $urandom_range(0, 3);
    endcase
  endfunction

  // Arm an allocated timer, binding it first if unbound (or at random); with none, allocate one.
  function automatic void arm_some_timer();
    int owned[$];
    int id;
    foreach (timer_st[i]) begin
      if (timer_st[i] == TimerAlloc) begin
        owned.push_back(i);
      end
    end
    if (owned.size() == 0) begin
      send(make_beat(ModeAlloc, $urandom, $urandom, $urandom, $urandom));
      return;
    end
    id = owned[$urandom_range(0, owned.size() - 1)];
    if (!timer_bound[id] || $urandom_range(0, 3) == 0) begin
      send(make_beat(ModeBind, id, $urandom, $urandom, $urandom));
    end
    send(make_beat(ModeArm, id, $urandom, $urandom, pick_delay()));
  endfunction

  function automatic void send_random(bit hold);
    in_beat_t b;
    int id;
    int pick;
    pick = $urandom_range(0, 99);
    b = make_beat(ModeTick, $urandom, $urandom, $urandom, $urandom);
    if (pick < 30) begin
      send(b, hold);
    end else if (pick < 50) begin
      b.mode = ModeAlloc;
      send(b, hold);
    end else if (pick < 72) begin
      arm_some_timer();
    end else if (pick < 82) begin
      b.mode = ModeFree;
      send(b, hold);
    end else if (pick < 90) begin
      b.mode = ModeBind;
      send(b, hold);
    end else if (pick < 96) begin
      // Arm of an arbitrary timer, only when it is bound or not allocated; else the tick goes out.
      id = int'(b.timer_id);
      if (timer_st[id] != TimerAlloc || timer_bound[id]) begin
        b.mode = ModeArm;
        b.delay = pick_delay();
      end
      send(b, hold);
    end else begin
      b.mode = 3'(ModeArm) + 3'($urandom_range(1, 3));
      send(b, hold);
    end
  endfunction

  function automatic void report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    errors++;
  endfunction

  // Record handshakes at the rising edge; the driver acts on them at the falling edge.
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
  end

  // Driver: holds a beat until it is taken, then offers the next one or idles.
  always @(negedge clk) begin
    int idle_pct;
    bit offer;
    idle_pct = beats_sent < 140 ? 18 : (beats_sent < 280 ? 74 : 0);
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        offer = 1;
      end else begin
        if (in_valid) begin
          beats_sent++;
        end
        offer = pending_beats.size() > 0 && $urandom_range(0, 99) >= idle_pct;
        if (offer && pending_beats[0].wait_for >= 0 &&
            results_seen < pending_beats[0].wait_for) begin
          offer = 0;
        end
        if (offer) begin
          in_beat <= pending_beats.pop_front().beat;
        end
      end
      in_valid <= offer;
    end
  end

  // Receiver stall, heavy first and light afterwards.
  always @(negedge clk) begin
    int stall_pct;
    stall_pct = beats_sent < 140 ? 74 : (beats_sent < 280 ? 18 : 0);
    if (rst_n) begin
      out_stall <= $urandom_range(0, 99) < stall_pct;
    end
  end

  // Monitor: each result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("unexpected beat", out_beat.data_out, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_beat.kind !== want.kind) begin
          report("kind", 32'(out_beat.kind), 32'(want.kind));
        end
        if (out_beat.status !== want.status) begin
          report("status", 32'(out_beat.status), 32'(want.status));
        end
        if (out_beat.handle !== want.handle) begin
          report("handle", 32'(out_beat.handle), 32'(want.handle));
        end
        if (out_beat.dest_out !== want.dest_out) begin
          report("dest_out", 32'(out_beat.dest_out), 32'(want.dest_out));
        end
        if (out_beat.data_out !== want.data_out) begin
          report("data_out", out_beat.data_out, want.data_out);
        end
        if (out_beat.last !== want.last) begin
          report("last", 32'(out_beat.last), 32'(want.last));
        end
      end
      results_seen++;
    end
  end

  initial begin
    clk = 0;
    rst_n = 0;
    in_valid = 0;
    in_beat = '0;
    out_stall = 0;
    in_taken = 0;
    tick_count = '0;
    results_predicted = 0;
    results_seen = 0;
    beats_sent = 0;
    errors = 0;
    foreach (timer_st[i]) begin
      timer_st[i] = TimerFree;
      timer_bound[i] = 0;
    end

    // Directed part: field extremes, rejections, ordering and wrapping deadlines.
    send(make_beat(ModeAlloc, 0, 0, 0, 0));
    send(make_beat(ModeBind, 0, 15, 32'h8000_0000, 0));
    send(make_beat(ModeArm, 0, 0, 0, 0));
    send(make_beat(ModeTick, 31, 15, 32'hffff_ffff, 32'hffff_ffff));
    send(make_beat(ModeAlloc, 31, 15, 32'hffff_ffff, 32'hffff_ffff));
    send(make_beat(ModeBind, 1, 0, 32'h7fff_ffff, 0));
    send(make_beat(ModeArm, 1, 0, 0, 32'hffff_ffff));
    send(make_beat(ModeArm, 1, 0, 0, 5));
    send(make_beat(ModeArm, 5, 0, 0, 5));
    send(make_beat(ModeAlloc, 0, 0, 0, 0));
    send(make_beat(ModeBind, 2, 5, 32'hffff_ffff, 0));
    send(make_beat(ModeArm, 2, 0, 0, 3));
    send(make_beat(ModeArm, 0, 0, 0, 3));
    send(make_beat(ModeFree, 2, 0, 0, 0));
    send(make_beat(ModeFree, 2, 0, 0, 0));
    send(make_beat(ModeBind, 31, 10, 32'h0, 0));
    send(make_beat(3'(ModeArm) + 3'd1, 31, 15, 32'hffff_ffff, 32'hffff_ffff));
    send(make_beat(3'(ModeArm) + 3'd2, 0, 0, 0, 0));
    send(make_beat(3'(ModeArm) + 3'd3, 31, 15, 32'hffff_ffff, 32'hffff_ffff));
    send(make_beat(ModeTick, 0, 0, 0, 0), 1);
    send(make_beat(ModeTick, 0, 0, 0, 0));
    send(make_beat(ModeTick, 0, 0, 0, 0));
    send(make_beat(ModeFree, 0, 0, 0, 32'hffff_ffff));

    // Random part, with an occasional pause until the pool has drained.
    for (int i = 0; i < RandomItems; i++) begin
      send_random(i % 60 == 59);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1;

    wait (pending_beats.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #15ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/sdtp_pkg.sv
hw/rtl/sdtp_ram.sv
hw/rtl/sorted_deadline_timer_pool_unit.sv
test/sorted_deadline_timer_pool_unit_test.sv
